@@ hw/rtl/fpba_pkg.sv @@
`default_nettype none

package fpba_pkg;

    // table geometry
    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;

    // fixed field widths of the streams
    localparam int CMD_W      = 1;
    localparam int BIDX_W     = 4;
    localparam int REQ_W      = 16;
    localparam int MODE_W     = 2;
    localparam int BCNT_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    // derived widths
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    // fit policies (the unused code behaves as first fit)
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic             clear;
        logic             sample;
        logic [IDX_W-1:0] index;
    } scan_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/fpba_ram.sv @@
`default_nettype none

module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                wdata,
    input  wire logic                            re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fpba_scan.sv @@
`default_nettype none

module fpba_scan (
    input  wire logic                             aclk,
    input  wire fpba_pkg::scan_ctl_t              ctl,
    input  wire logic [fpba_pkg::SIZE_BITS-1:0]   entry,
    input  wire logic [fpba_pkg::REQ_W-1:0]       request,
    input  wire logic [fpba_pkg::MODE_W-1:0]      fit_mode,
    output logic                                  found,
    output logic [fpba_pkg::IDX_W-1:0]            pick,
    output logic [fpba_pkg::SIZE_BITS-1:0]        pick_size
);

    logic                           found_reg;
    logic [fpba_pkg::IDX_W-1:0]     pick_reg;
    logic [fpba_pkg::SIZE_BITS-1:0] size_reg;
    logic                           fits;
    logic                           take;

    always_comb begin
        fits = fpba_pkg::CMP_W'(entry) >= fpba_pkg::CMP_W'(request);
        take = 1'b0;
        if (fits) begin
            if (!found_reg) begin
                take = 1'b1;
            end else if (fit_mode == fpba_pkg::MODE_BEST) begin
                take = entry < size_reg;
            end else if (fit_mode == fpba_pkg::MODE_WORST) begin
                take = entry > size_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            found_reg <= 1'b0;
        end else if (ctl.sample && take) begin
            found_reg <= 1'b1;
            pick_reg  <= ctl.index;
            size_reg  <= entry;
        end
    end

    assign found     = found_reg;
    assign pick      = pick_reg;
    assign pick_size = size_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fit_policy_block_allocator.sv @@
`default_nettype none

// channel   direction  handshake               payload
// s_        in         s_tvalid / s_tready     s_tdata, s_tuser (command)
// m_        out        m_tvalid / m_tready     m_tdata, m_tuser (granted)
// cfg_      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a load is accepted in idle, even while a result waits on m_
// an allocate reads min(block_count, MAX_BLOCKS) entries, one table read a cycle
// through the single read port, then drains the last read and writes back the
// chosen entry at the finishing step, which holds while the previous result
// has not been transferred
// reset (aresetn, synchronous, active low) clears control; table contents stay
// undefined until loaded

module fit_policy_block_allocator (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // tdata: block_index [3:0], size_value [19:4], zero [23:20]
    input  wire logic [fpba_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser: command [0]
    input  wire logic [fpba_pkg::CMD_W-1:0]         s_tuser,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tdata: granted_block [3:0], zero [7:4]
    output logic [fpba_pkg::M_TDATA_W-1:0]          m_tdata,
    // tuser: granted [0]
    output logic                                    m_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [fpba_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data
);

    fpba_pkg::state_t               state_reg, state_next;

    logic [fpba_pkg::MODE_W-1:0]    fit_mode_reg;
    logic [fpba_pkg::BCNT_W-1:0]    block_count_reg;

    logic [fpba_pkg::REQ_W-1:0]     req_reg;
    logic [fpba_pkg::CNT_W-1:0]     limit_reg;
    logic [fpba_pkg::CNT_W-1:0]     issue_reg;
    logic                           samp_vld_reg;
    logic [fpba_pkg::IDX_W-1:0]     samp_idx_reg;

    logic                           out_vld_reg;
    logic                           out_granted_reg;
    logic [fpba_pkg::BIDX_W-1:0]    out_block_reg;

    // unpacked input fields
    logic [fpba_pkg::BIDX_W-1:0]    in_block_index;
    logic [fpba_pkg::REQ_W-1:0]     in_size_value;
    logic                           in_xfer;

    // control decoded from state
    logic                           load_we;
    logic                           start_alloc;
    logic                           rd_en;
    logic [fpba_pkg::IDX_W-1:0]     rd_addr;
    logic                           scan_done;
    logic                           slot_free;
    logic                           finish_go;

    logic                           ram_we;
    logic [fpba_pkg::IDX_W-1:0]     ram_waddr;
    logic [fpba_pkg::SIZE_BITS-1:0] ram_wdata;
    logic [fpba_pkg::SIZE_BITS-1:0] ram_rdata;

    logic [fpba_pkg::CNT_W-1:0]     limit_new;

    fpba_pkg::scan_ctl_t            scan_ctl;
    logic                           scan_found;
    logic [fpba_pkg::IDX_W-1:0]     scan_pick;
    logic [fpba_pkg::SIZE_BITS-1:0] scan_size;

    assign in_block_index = s_tdata[fpba_pkg::BIDX_W-1:0];
    assign in_size_value  = s_tdata[fpba_pkg::BIDX_W +: fpba_pkg::REQ_W];
    assign in_xfer        = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    // entries scanned, capped at the table depth
    always_comb begin
        if (int'(block_count_reg) > fpba_pkg::MAX_BLOCKS) begin
            limit_new = fpba_pkg::CNT_W'(fpba_pkg::MAX_BLOCKS);
        end else begin
            limit_new = fpba_pkg::CNT_W'(block_count_reg);
        end
    end

    assign slot_free = !out_vld_reg || m_tready;
    // the last read is sampled at the same edge that leaves the scan
    assign scan_done = (issue_reg == limit_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fpba_pkg::ST_IDLE: begin
                if (in_xfer && s_tuser == fpba_pkg::CMD_ALLOC) begin
                    state_next = fpba_pkg::ST_SCAN;
                end
            end
            fpba_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = fpba_pkg::ST_FINISH;
                end
            end
            fpba_pkg::ST_FINISH: begin
                if (slot_free) begin
                    state_next = fpba_pkg::ST_IDLE;
                end
            end
            default: state_next = fpba_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready    = 1'b0;
        load_we     = 1'b0;
        start_alloc = 1'b0;
        rd_en       = 1'b0;
        finish_go   = 1'b0;
        unique case (state_reg)
            fpba_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                load_we     = in_xfer && s_tuser == fpba_pkg::CMD_LOAD
                              && int'(in_block_index) < fpba_pkg::MAX_BLOCKS;
                start_alloc = in_xfer && s_tuser == fpba_pkg::CMD_ALLOC;
            end
            fpba_pkg::ST_SCAN: begin
                rd_en = issue_reg != limit_reg;
            end
            fpba_pkg::ST_FINISH: begin
                finish_go = slot_free;
            end
            default: begin
            end
        endcase
    end

    assign rd_addr = issue_reg[fpba_pkg::IDX_W-1:0];

    // one write port: loads in idle, write-back of the chosen entry at finish
    always_comb begin
        if (load_we) begin
            ram_we    = 1'b1;
            ram_waddr = fpba_pkg::IDX_W'(in_block_index);
            ram_wdata = fpba_pkg::SIZE_BITS'(in_size_value);
        end else begin
            ram_we    = finish_go && scan_found;
            ram_waddr = scan_pick;
            ram_wdata = scan_size - fpba_pkg::SIZE_BITS'(req_reg);
        end
    end

    fpba_ram #(
        .WIDTH (fpba_pkg::SIZE_BITS),
        .DEPTH (fpba_pkg::MAX_BLOCKS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign scan_ctl.clear  = start_alloc;
    assign scan_ctl.sample = samp_vld_reg;
    assign scan_ctl.index  = samp_idx_reg;

    fpba_scan u_scan (
        .aclk      (aclk),
        .ctl       (scan_ctl),
        .entry     (ram_rdata),
        .request   (req_reg),
        .fit_mode  (fit_mode_reg),
        .found     (scan_found),
        .pick      (scan_pick),
        .pick_size (scan_size)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= fpba_pkg::ST_IDLE;
            fit_mode_reg    <= fpba_pkg::MODE_FIRST;
            block_count_reg <= fpba_pkg::BCNT_W'(16);
            samp_vld_reg    <= 1'b0;
            out_vld_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            samp_vld_reg <= rd_en;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    fpba_pkg::REG_FIT_MODE:
                        fit_mode_reg <= cfg_data[fpba_pkg::MODE_W-1:0];
                    fpba_pkg::REG_BLOCK_COUNT:
                        block_count_reg <= cfg_data[fpba_pkg::BCNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (finish_go) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (start_alloc) begin
            req_reg   <= in_size_value;
            limit_reg <= limit_new;
            issue_reg <= '0;
        end else if (rd_en) begin
            issue_reg <= issue_reg + fpba_pkg::CNT_W'(1);
        end
        samp_idx_reg <= rd_addr;
        if (finish_go) begin
            out_granted_reg <= scan_found;
            out_block_reg   <= scan_found ? fpba_pkg::BIDX_W'(scan_pick) : '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_granted_reg;
    assign m_tdata  = {{(fpba_pkg::M_TDATA_W - fpba_pkg::BIDX_W){1'b0}}, out_block_reg};

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import fpba_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int SETTLE_CYCLES   = 24;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 100;
    // the final phases run with both sides flowing freely
    localparam int QUIET_PHASES    = 3;

    typedef struct packed {
        logic              granted;
        logic [BIDX_W-1:0] block;
    } grant_t;

    // mirror of the free size table and of the two policy registers
    class grant_predictor;
        logic [SIZE_BITS-1:0] free_sizes [MAX_BLOCKS];
        logic [MODE_W-1:0]    mode;
        logic [BCNT_W-1:0]    blocks_in_use;
        grant_t               pending_grants [$];
        int                   mismatches;

        function new();
            mode          = MODE_FIRST;
            blocks_in_use = BCNT_W'(MAX_BLOCKS);
            mismatches    = 0;
            foreach (free_sizes[k]) free_sizes[k] = '0;
        endfunction

        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_FIT_MODE) begin
                mode = data[MODE_W-1:0];
            end else begin
                blocks_in_use = data[BCNT_W-1:0];
            end
        endfunction

        // a load updates the table, an allocate queues the grant it should produce
        function void note_command(logic [CMD_W-1:0] cmd, logic [BIDX_W-1:0] idx,
                                   logic [REQ_W-1:0] size);
            int     scan_len;
            int     pick;
            int     k;
            bit     found;
            grant_t g;
            if (cmd == CMD_LOAD) begin
                free_sizes[idx] = SIZE_BITS'(size);
                return;
            end
            scan_len = (int'(blocks_in_use) > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_in_use);
            found    = 1'b0;
            pick     = 0;
            for (k = 0; k < scan_len; k++) begin
                if (free_sizes[k] < size) continue;
                if (!found) begin
                    found = 1'b1;
                    pick  = k;
                    // first fit and the spare code stop at the first candidate
                    if (mode != MODE_BEST && mode != MODE_WORST) break;
                end else if (mode == MODE_BEST && free_sizes[k] < free_sizes[pick]) begin
                    pick = k;
                end else if (mode == MODE_WORST && free_sizes[k] > free_sizes[pick]) begin
                    pick = k;
                end
            end
            if (found) begin
                free_sizes[pick] = free_sizes[pick] - SIZE_BITS'(size);
                g.granted        = 1'b1;
                g.block          = BIDX_W'(pick);
            end else begin
                g = '0;
            end
            pending_grants.push_back(g);
        endfunction

        function void check_grant(logic granted, logic [BIDX_W-1:0] block);
            grant_t want;
            if (pending_grants.size() == 0) begin
                $error("unexpected result transfer: granted %0d granted_block %0d",
                       granted, block);
                mismatches++;
                return;
            end
            want = pending_grants.pop_front();
            if (granted !== want.granted) begin
                $error("granted: expected %0d, actual %0d", want.granted, granted);
                mismatches++;
            end
            if (block !== want.block) begin
                $error("granted_block: expected %0d, actual %0d", want.block, block);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_grants.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    // tdata: block_index [3:0], size_value [19:4], zero [23:20]
    logic [S_TDATA_W-1:0]  s_tdata;
    // tuser: command [0]
    logic [CMD_W-1:0]      s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    // tdata: granted_block [3:0], zero [7:4]
    logic [M_TDATA_W-1:0]  m_tdata;
    // tuser: granted [0]
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // random gaps on the sender and stalls on the receiver while set
    bit                    idling_on = 1'b1;
    int unsigned           cycle_count = 0;
    grant_predictor        tracker = new();

    // opening table contents: ties, both size extremes and a spread in between
    logic [SIZE_BITS-1:0]  opening_sizes [MAX_BLOCKS] = '{
        16'd100,  16'hFFFF, 16'd50,   16'd300,  16'd50,   16'd0,    16'hFFFF, 16'd300,
        16'h8000, 16'h7FFF, 16'd1,    16'd2,    16'h5555, 16'hAAAA, 16'd50,   16'd200
    };

    fit_policy_block_allocator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // watchdog: generous against the slowest correct run with full idling
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // every result transfer is checked against the oldest predicted grant
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_grant(m_tuser, m_tdata[BIDX_W-1:0]);
        end
    end

    // receiver: random stall bursts while idling is on
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    // one transfer on the input stream; s_tvalid stays high for a following item
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [BIDX_W-1:0] idx,
                                logic [REQ_W-1:0] size);
        @(negedge aclk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tdata  = {{(S_TDATA_W - REQ_W - BIDX_W){1'b0}}, size, idx};
        s_tuser  = cmd;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_command(cmd, idx, size);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        tracker.note_register(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // stop the stream, let every grant come back and a trailing load finish
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reconfigure(logic [CFG_DATA_W-1:0] mode_data,
                               logic [CFG_DATA_W-1:0] count_data);
        drain();
        write_register(REG_FIT_MODE, mode_data);
        write_register(REG_BLOCK_COUNT, count_data);
    endtask

    // loads refill the table, allocates lean on ties, exact fits and empties
    task automatic random_command();
        int                   pick;
        logic [REQ_W-1:0]     size;
        logic [BIDX_W-1:0]    idx;
        idx  = BIDX_W'($urandom_range(0, MAX_BLOCKS - 1));
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 35) begin
            if (pick < 30) begin
                size = REQ_W'($urandom_range(0, 300));
            end else if (pick < 50) begin
                size = ($urandom_range(0, 1) == 0) ? '0 : '1;
            end else begin
                size = REQ_W'($urandom);
            end
            send_command(CMD_LOAD, idx, size);
        end else begin
            if (pick < 15) begin
                size = '0;
            end else if (pick < 45) begin
                // exact fit against some current entry
                size = REQ_W'(tracker.free_sizes[$urandom_range(0, MAX_BLOCKS - 1)]);
            end else if (pick < 75) begin
                size = REQ_W'($urandom_range(1, 300));
            end else begin
                size = REQ_W'($urandom);
            end
            send_command(CMD_ALLOC, idx, size);
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] mode_data;
        logic [CFG_DATA_W-1:0] count_data;
        int                    sel;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_LOAD;
        cfg_valid = 1'b0;
        cfg_index = REG_FIT_MODE;
        cfg_data  = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: load every entry before any allocate scans it
        reconfigure(CFG_DATA_W'(MODE_FIRST), CFG_DATA_W'(MAX_BLOCKS));
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            send_command(CMD_LOAD, BIDX_W'(k), opening_sizes[k]);
        end
        // zero request takes the first entry and leaves it as it is
        send_command(CMD_ALLOC, 4'hF, 16'h0000);
        // full-size requests use up both largest entries, then nothing fits
        repeat (3) send_command(CMD_ALLOC, 4'h0, 16'hFFFF);
        // best fit with a three-way tie resolves to the lowest index
        reconfigure(CFG_DATA_W'(MODE_BEST), CFG_DATA_W'(MAX_BLOCKS));
        send_command(CMD_ALLOC, 4'h5, 16'd50);
        reconfigure(CFG_DATA_W'(MODE_WORST), CFG_DATA_W'(MAX_BLOCKS));
        send_command(CMD_ALLOC, 4'hA, 16'd1);
        // spare policy code falls back to first fit
        reconfigure(CFG_DATA_W'(2'd3), CFG_DATA_W'(MAX_BLOCKS));
        send_command(CMD_ALLOC, 4'h0, 16'd10);
        // empty scan never grants
        reconfigure(CFG_DATA_W'(MODE_FIRST), '0);
        send_command(CMD_ALLOC, 4'h0, 16'd0);
        // oversized count is clipped to the table depth
        reconfigure(CFG_DATA_W'(MODE_BEST), '1);
        send_command(CMD_ALLOC, 4'h0, 16'd200);
        reconfigure(CFG_DATA_W'(MODE_WORST), CFG_DATA_W'(1));
        send_command(CMD_ALLOC, 4'h0, 16'd101);

        // random phases, each under a fresh policy setting
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode_data = CFG_DATA_W'($urandom_range(0, 31));
            sel       = $urandom_range(0, 9);
            if (sel < 7) begin
                count_data = CFG_DATA_W'($urandom_range(1, MAX_BLOCKS));
            end else if (sel == 7) begin
                count_data = CFG_DATA_W'(MAX_BLOCKS);
            end else if (sel == 8) begin
                count_data = '0;
            end else begin
                count_data = CFG_DATA_W'($urandom_range(MAX_BLOCKS + 1, 31));
            end
            reconfigure(mode_data, count_data);
            idling_on = (p < RANDOM_PHASES - QUIET_PHASES);
            repeat (ITEMS_PER_PHASE) random_command();
        end

        drain();
        if (tracker.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
